// ===== rtl/spm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_pkg
// Shared types and constants of the streaming pattern matcher.
// ----------------------------------------------------------------------------
package spm_pkg;

  localparam int MAX_PATTERN_BYTES = 64;
  localparam int IDX_W             = $clog2(MAX_PATTERN_BYTES);
  localparam int LEN_W             = 7;
  localparam int POSITION_BITS     = 24;
  localparam int START_W           = 24;
  localparam int KIND_W            = 2;
  localparam int DATA_W            = 8;
  localparam int PIDX_W            = 6;

  localparam logic [POSITION_BITS-1:0] POS_MAX = {POSITION_BITS{1'b1}};

  typedef enum logic [KIND_W-1:0] {
    KIND_LOAD    = 2'd0,
    KIND_TEXT    = 2'd1,
    KIND_RESTART = 2'd2,
    KIND_NONE    = 2'd3
  } kind_t;

  // controls seen by one cell
  typedef struct packed {
    logic              shift;
    logic              clear;
    logic              insert;
    logic              active;
    logic              pat_we;
    logic [DATA_W-1:0] data;
  } cell_ctl_t;

  // controls broadcast to the whole row
  typedef struct packed {
    logic              shift;
    logic              clear;
    logic              insert;
    logic              pat_we;
    logic [IDX_W-1:0]  pat_idx;
    logic [IDX_W-1:0]  tail;
    logic [DATA_W-1:0] data;
  } row_ctl_t;

endpackage

// ===== rtl/spm_if.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_if
// Valid/ready channels of the streaming pattern matcher.
// ----------------------------------------------------------------------------
interface spm_item_if;
  logic                       valid;
  logic                       ready;
  logic [spm_pkg::KIND_W-1:0] kind;
  logic [spm_pkg::PIDX_W-1:0] pattern_index;
  logic [spm_pkg::DATA_W-1:0] byte_value;

  modport source (output valid, kind, pattern_index, byte_value, input ready);
  modport sink   (input valid, kind, pattern_index, byte_value, output ready);
endinterface

interface spm_result_if;
  logic                        valid;
  logic                        ready;
  logic [spm_pkg::START_W-1:0] match_start;
  logic                        position_saturated;

  modport source (output valid, match_start, position_saturated, input ready);
  modport sink   (input valid, match_start, position_saturated, output ready);
endinterface

interface spm_cfg_if;
  logic                      valid;
  logic                      ready;
  logic [spm_pkg::LEN_W-1:0] data;

  modport source (output valid, data, input ready);
  modport sink   (input valid, data, output ready);
endinterface

// ===== rtl/spm_cell.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_cell
// One matcher cell: a window byte, a pattern byte and their compare.
// ----------------------------------------------------------------------------
module spm_cell (
  input  logic                       clk,
  input  logic                       rst,
  input  spm_pkg::cell_ctl_t         ctl,
  input  logic [spm_pkg::DATA_W-1:0] right_in,
  output logic [spm_pkg::DATA_W-1:0] win,
  output logic                       ok
);

  logic [spm_pkg::DATA_W-1:0] pat;

  always_ff @(posedge clk) begin
    if (rst) begin
      win <= '0;
    end else if (ctl.clear) begin
      win <= '0;
    end else if (ctl.shift) begin
      win <= ctl.insert ? ctl.data : right_in;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pat_we) begin
      pat <= ctl.data;
    end
  end

  // cells past the pattern end never block a match
  assign ok = !ctl.active || (win == pat);

endmodule

// ===== rtl/spm_row.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// spm_row
// Ring of matcher cells; cell k lines up with pattern byte k.
// ----------------------------------------------------------------------------
module spm_row (
  input  logic              clk,
  input  logic              rst,
  input  spm_pkg::row_ctl_t ctl,
  output logic              all_ok
);

  localparam int N = spm_pkg::MAX_PATTERN_BYTES;

  logic [spm_pkg::DATA_W-1:0] win [N];
  logic [N-1:0]               ok;

  for (genvar k = 0; k < N; k++) begin : g_cell
    spm_pkg::cell_ctl_t cctl;

    always_comb begin
      cctl.shift  = ctl.shift;
      cctl.clear  = ctl.clear;
      cctl.insert = ctl.insert && (ctl.tail == spm_pkg::IDX_W'(k));
      cctl.active = (spm_pkg::IDX_W'(k) <= ctl.tail);
      cctl.pat_we = ctl.pat_we && (ctl.pat_idx == spm_pkg::IDX_W'(k));
      cctl.data   = ctl.data;
    end

    spm_cell u_cell (
      .clk      (clk),
      .rst      (rst),
      .ctl      (cctl),
      .right_in (win[(k + 1) % N]),
      .win      (win[k]),
      .ok       (ok[k])
    );
  end

  assign all_ok = &ok;

endmodule

// ===== rtl/streaming_pattern_matcher.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// streaming_pattern_matcher
// Reports the start position of every occurrence of a stored pattern.
// ----------------------------------------------------------------------------
// The pattern and the last 64 text bytes sit in a ring of 64 cells, each
// comparing its window byte with its pattern byte. A text word enters the
// ring in the cycle it is accepted and is compared in the next; the next
// word is taken in that same cycle, so words stream at one per cycle while
// results drain, and the result register stalls input only when it is full.
// Writing pattern_length realigns the ring one cell per cycle; input words
// are held off until the realignment is done.
// ----------------------------------------------------------------------------
module streaming_pattern_matcher (
  input  logic                clk,
  input  logic                rst,
  spm_item_if.sink            item,
  spm_result_if.source        result,
  spm_cfg_if.sink             cfg
);

  logic [spm_pkg::LEN_W-1:0]         pattern_length;
  logic [spm_pkg::IDX_W-1:0]         tail;
  logic [spm_pkg::IDX_W-1:0]         target;
  logic [spm_pkg::LEN_W-1:0]         len_m1;
  logic [spm_pkg::LEN_W-1:0]         fill;
  logic [spm_pkg::POSITION_BITS-1:0] position;
  logic                              eval;
  logic [spm_pkg::POSITION_BITS-1:0] eval_here;
  logic                              eval_sat;
  logic [spm_pkg::POSITION_BITS-1:0] start_pos;
  logic                              busy;
  logic                              fire;
  logic                              accept;
  logic                              take_text;
  logic                              take_load;
  logic                              take_restart;
  logic                              all_ok;
  logic                              match;
  spm_pkg::row_ctl_t                 rctl;

  // ring alignment target from the clamped length
  always_comb begin
    len_m1 = pattern_length - spm_pkg::LEN_W'(1);
    if (pattern_length == '0) begin
      target = '0;
    end else if (pattern_length > spm_pkg::LEN_W'(spm_pkg::MAX_PATTERN_BYTES)) begin
      target = spm_pkg::IDX_W'(spm_pkg::MAX_PATTERN_BYTES - 1);
    end else begin
      target = len_m1[spm_pkg::IDX_W-1:0];
    end
  end

  assign busy         = (tail != target);
  assign fire         = eval && (!result.valid || result.ready);
  assign item.ready   = !busy && (!eval || fire);
  assign cfg.ready    = 1'b1;
  assign accept       = item.valid && item.ready;
  assign take_text    = accept && (item.kind == spm_pkg::KIND_TEXT);
  assign take_load    = accept && (item.kind == spm_pkg::KIND_LOAD);
  assign take_restart = accept && (item.kind == spm_pkg::KIND_RESTART);

  always_comb begin
    rctl.shift   = take_text || busy;
    rctl.clear   = take_restart;
    rctl.insert  = take_text;
    rctl.pat_we  = take_load &&
                   (int'(item.pattern_index) < spm_pkg::MAX_PATTERN_BYTES);
    rctl.pat_idx = spm_pkg::IDX_W'(item.pattern_index);
    rctl.tail    = tail;
    rctl.data    = item.byte_value;
  end

  spm_row u_row (
    .clk    (clk),
    .rst    (rst),
    .ctl    (rctl),
    .all_ok (all_ok)
  );

  assign match     = all_ok &&
                     (fill >= (spm_pkg::LEN_W'(tail) + spm_pkg::LEN_W'(1)));
  assign start_pos = eval_here - spm_pkg::POSITION_BITS'(tail);

  always_ff @(posedge clk) begin
    if (rst) begin
      pattern_length <= spm_pkg::LEN_W'(1);
      tail           <= '0;
      fill           <= '0;
      position       <= '0;
      eval           <= 1'b0;
      result.valid   <= 1'b0;
    end else begin
      if (cfg.valid && cfg.ready) begin
        pattern_length <= cfg.data;
      end
      // each rotation step moves the alignment down by one cell
      if (busy) begin
        tail <= tail - spm_pkg::IDX_W'(1);
      end
      if (take_restart) begin
        fill     <= '0;
        position <= '0;
      end else if (take_text) begin
        if (fill < spm_pkg::LEN_W'(spm_pkg::MAX_PATTERN_BYTES)) begin
          fill <= fill + spm_pkg::LEN_W'(1);
        end
        if (position != spm_pkg::POS_MAX) begin
          position <= position + spm_pkg::POSITION_BITS'(1);
        end
      end
      if (take_text) begin
        eval <= 1'b1;
      end else if (fire) begin
        eval <= 1'b0;
      end
      if (fire && match) begin
        result.valid <= 1'b1;
      end else if (result.ready) begin
        result.valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (take_text) begin
      eval_here <= position;
      eval_sat  <= (position == spm_pkg::POS_MAX);
    end
    if (fire && match) begin
      result.match_start        <= start_pos[spm_pkg::START_W-1:0];
      result.position_saturated <= eval_sat;
    end
  end

`ifndef SYNTH
  a_rise_after_eval: assert property (@(posedge clk) disable iff (rst)
    $rose(result.valid) |-> $past(eval))
    else $error("result word appeared without a compare");

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= spm_pkg::LEN_W'(spm_pkg::MAX_PATTERN_BYTES))
    else $error("window fill beyond ring size");

  a_rotate_step: assert property (@(posedge clk) disable iff (rst)
    busy |=> (tail == $past(tail) - spm_pkg::IDX_W'(1)))
    else $error("ring realignment skipped a step");

  a_no_text_while_rotating: assert property (@(posedge clk) disable iff (rst)
    busy |-> !rctl.insert)
    else $error("text word inserted during realignment");
`endif

endmodule

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the streaming pattern matcher.
// ----------------------------------------------------------------------------
// Loads the pattern table, then runs directed checks on one-byte patterns,
// short text after a restart, and a zero length. After that come
// random phases at many pattern lengths. Most words in those phases form
// occurrences of the stored pattern, some with one byte flipped, and the
// rest are noise, loads, restarts and unused kinds. A local model predicts
// every match, and a monitor compares each result word in order. Both sides
// idle in random bursts, except in the last phases.
// ----------------------------------------------------------------------------
module testbench;

  localparam int DRAIN_CYCLES = 8;

  typedef struct {
    logic [spm_pkg::START_W-1:0] start;
    logic                        saturated;
  } match_t;

  logic clk = 1'b0;
  logic rst;

  spm_item_if   item_ch ();
  spm_result_if result_ch ();
  spm_cfg_if    cfg_ch ();

  streaming_pattern_matcher u_dut (
    .clk    (clk),
    .rst    (rst),
    .item   (item_ch),
    .result (result_ch),
    .cfg    (cfg_ch)
  );

  // matcher state as the model sees it
  logic [spm_pkg::DATA_W-1:0]        pattern_bytes [spm_pkg::MAX_PATTERN_BYTES];
  logic [spm_pkg::DATA_W-1:0]        text_bytes [spm_pkg::MAX_PATTERN_BYTES];
  int unsigned                       text_fill;
  logic [spm_pkg::POSITION_BITS-1:0] text_pos;
  logic [spm_pkg::LEN_W-1:0]         pattern_len;

  match_t expected_matches [$];

  bit bursts_on;
  int word_count;
  int match_count;
  int length_writes;
  int error_count;

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  task automatic flag_error(input string msg);
    $display("ERROR @%0t: %s", $realtime, msg);
    error_count++;
  endtask

  function automatic int unsigned active_len();
    if (pattern_len == 0) return 1;
    if (pattern_len > spm_pkg::MAX_PATTERN_BYTES) return spm_pkg::MAX_PATTERN_BYTES;
    return 32'(pattern_len);
  endfunction

  function automatic void predict_word(input spm_pkg::kind_t k,
                                       input logic [spm_pkg::PIDX_W-1:0] idx,
                                       input logic [spm_pkg::DATA_W-1:0] value);
    int unsigned eff;
    int          i;
    bit          hit;
    match_t      m;
    case (k)
      spm_pkg::KIND_LOAD: begin
        pattern_bytes[idx] = value;
      end
      spm_pkg::KIND_RESTART: begin
        for (i = 0; i < spm_pkg::MAX_PATTERN_BYTES; i++) text_bytes[i] = '0;
        text_fill = 0;
        text_pos  = '0;
      end
      spm_pkg::KIND_TEXT: begin
        for (i = spm_pkg::MAX_PATTERN_BYTES - 1; i > 0; i--) text_bytes[i] = text_bytes[i-1];
        text_bytes[0] = value;
        if (text_fill < spm_pkg::MAX_PATTERN_BYTES) text_fill++;
        m.saturated = (text_pos == spm_pkg::POS_MAX);
        m.start     = text_pos;
        if (!m.saturated) text_pos = text_pos + spm_pkg::POSITION_BITS'(1);
        eff = active_len();
        hit = (text_fill >= eff);
        for (i = 0; i < eff; i++) begin
          if (text_bytes[eff-1-i] != pattern_bytes[i]) hit = 1'b0;
        end
        if (hit) begin
          m.start = m.start - spm_pkg::START_W'(eff - 1);
          expected_matches.push_back(m);
        end
      end
      default: ;
    endcase
  endfunction

  // Hold valid across back-to-back words; drop it only for an idle burst.
  task automatic send_word(input spm_pkg::kind_t k,
                           input logic [spm_pkg::PIDX_W-1:0] idx,
                           input logic [spm_pkg::DATA_W-1:0] value);
    if (bursts_on && $urandom_range(0, 4) == 0) begin
      item_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 11)) @(posedge clk);
    end
    item_ch.valid         <= 1'b1;
    item_ch.kind          <= k;
    item_ch.pattern_index <= idx;
    item_ch.byte_value    <= value;
    @(posedge clk);
    while (!item_ch.ready) @(posedge clk);
    predict_word(k, idx, value);
    word_count++;
  endtask

  task automatic send_text(input logic [spm_pkg::DATA_W-1:0] value);
    send_word(spm_pkg::KIND_TEXT, '0, value);
  endtask

  // Stop sending and wait for every match in flight to come out.
  task automatic wait_idle();
    item_ch.valid <= 1'b0;
    while (expected_matches.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  task automatic write_length(input logic [spm_pkg::LEN_W-1:0] len);
    wait_idle();
    cfg_ch.valid <= 1'b1;
    cfg_ch.data  <= len;
    @(posedge clk);
    while (!cfg_ch.ready) @(posedge clk);
    cfg_ch.valid <= 1'b0;
    pattern_len = len;
    length_writes++;
  endtask

  task automatic load_pattern_table();
    int i;
    for (i = 0; i < spm_pkg::MAX_PATTERN_BYTES; i++) begin
      if (i == 0) begin
        send_word(spm_pkg::KIND_LOAD, spm_pkg::PIDX_W'(i), 8'h00);
      end else if (i == spm_pkg::MAX_PATTERN_BYTES - 1) begin
        send_word(spm_pkg::KIND_LOAD, spm_pkg::PIDX_W'(i), 8'hFF);
      end else begin
        send_word(spm_pkg::KIND_LOAD, spm_pkg::PIDX_W'(i),
                  spm_pkg::DATA_W'($urandom_range(0, 255)));
      end
    end
  endtask

  // Reset length is one; a zero pattern byte must not match the cleared window.
  task automatic test_single_byte_pattern();
    send_text(8'h00);
    send_text(8'hFF);
    send_word(spm_pkg::KIND_NONE, 6'h3F, 8'h00);
    send_text(8'h00);
    send_word(spm_pkg::KIND_LOAD, 6'd0, 8'hFF);
    send_text(8'hFF);
    send_word(spm_pkg::KIND_RESTART, '0, '0);
    send_text(8'hFF);
  endtask

  // No match before the window holds a full pattern; overlapping matches.
  task automatic test_short_text();
    int i;
    write_length(7'd4);
    for (i = 0; i < 4; i++) send_word(spm_pkg::KIND_LOAD, spm_pkg::PIDX_W'(i), 8'h5A);
    send_word(spm_pkg::KIND_RESTART, '0, '0);
    repeat (3) send_text(8'h5A);
    send_word(spm_pkg::KIND_RESTART, '0, '0);
    repeat (6) send_text(8'h5A);
  endtask

  task automatic test_length_zero();
    write_length(7'd0);
    send_text(8'h5A);
    send_text(8'hA5);
  endtask

  task automatic test_random_streams();
    logic [spm_pkg::LEN_W-1:0]  lengths [12] = '{7'd2, 7'd127, 7'd5, 7'd1, 7'd16, 7'd0,
                                                7'd33, 7'd64, 7'd3, 7'd65, 7'd7, 7'd2};
    logic [spm_pkg::DATA_W-1:0] alphabet [2] = '{8'hA5, 8'h5A};
    logic [spm_pkg::DATA_W-1:0] value;
    int                         p, i, eff, flip, phase_end;
    bit                         alpha_mode;
    for (p = 0; p < 12; p++) begin
      bursts_on = (p < 10);
      write_length(lengths[p]);
      eff = int'(active_len());
      alpha_mode = (eff <= 16) && ($urandom_range(0, 1) == 1);
      if (alpha_mode) begin
        for (i = 0; i < eff; i++) begin
          send_word(spm_pkg::KIND_LOAD, spm_pkg::PIDX_W'(i), alphabet[$urandom_range(0, 1)]);
        end
      end
      phase_end = word_count + 20 + eff;
      while (word_count < phase_end) begin
        case ($urandom_range(0, 19))
          0, 1, 2, 3, 4, 5, 6, 7, 8, 9, 10, 11: begin
            // one occurrence, sometimes with a single bit flipped
            flip = ($urandom_range(0, 3) == 0) ? $urandom_range(0, eff - 1) : -1;
            for (i = 0; i < eff; i++) begin
              value = pattern_bytes[i];
              if (i == flip) value = value ^ (8'h01 << $urandom_range(0, 7));
              send_text(value);
            end
          end
          12, 13, 14: begin
            repeat ($urandom_range(1, 5)) begin
              value = alpha_mode ? alphabet[$urandom_range(0, 1)]
                                 : spm_pkg::DATA_W'($urandom_range(0, 255));
              send_text(value);
            end
          end
          15, 16: begin
            value = alpha_mode ? alphabet[$urandom_range(0, 1)]
                               : spm_pkg::DATA_W'($urandom_range(0, 255));
            send_word(spm_pkg::KIND_LOAD,
                      spm_pkg::PIDX_W'($urandom_range(0, spm_pkg::MAX_PATTERN_BYTES - 1)),
                      value);
          end
          17: send_word(spm_pkg::KIND_RESTART, spm_pkg::PIDX_W'($urandom_range(0, 63)),
                        spm_pkg::DATA_W'($urandom_range(0, 255)));
          default: send_word(spm_pkg::KIND_NONE, spm_pkg::PIDX_W'($urandom_range(0, 63)),
                             spm_pkg::DATA_W'($urandom_range(0, 255)));
        endcase
      end
    end
  endtask

  // result monitor
  always @(posedge clk) begin : check_results
    match_t want;
    if (!rst && result_ch.valid && result_ch.ready) begin
      if (expected_matches.size() == 0) begin
        flag_error($sformatf("unexpected match at %0d", result_ch.match_start));
      end else begin
        want = expected_matches.pop_front();
        match_count++;
        if (result_ch.match_start !== want.start)
          flag_error($sformatf("match_start %0d, want %0d", result_ch.match_start, want.start));
        if (result_ch.position_saturated !== want.saturated)
          flag_error($sformatf("position_saturated %0b, want %0b",
                               result_ch.position_saturated, want.saturated));
      end
    end
  end

  // result back-pressure in bursts
  initial begin
    result_ch.ready = 1'b0;
    @(posedge clk);
    while (rst) @(posedge clk);
    forever begin
      if (bursts_on && $urandom_range(0, 3) == 0) begin
        result_ch.ready <= 1'b0;
        repeat ($urandom_range(1, 11)) @(posedge clk);
      end
      result_ch.ready <= 1'b1;
      repeat ($urandom_range(1, 20)) @(posedge clk);
    end
  end

  initial begin
    int guard;
    rst                   = 1'b1;
    item_ch.valid         = 1'b0;
    item_ch.kind          = spm_pkg::KIND_LOAD;
    item_ch.pattern_index = '0;
    item_ch.byte_value    = '0;
    cfg_ch.valid          = 1'b0;
    cfg_ch.data           = '0;
    bursts_on             = 1'b1;
    word_count            = 0;
    match_count           = 0;
    length_writes         = 0;
    error_count           = 0;
    predict_word(spm_pkg::KIND_RESTART, '0, '0);
    pattern_len = 7'd1;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    load_pattern_table();
    test_single_byte_pattern();
    test_short_text();
    test_length_zero();
    test_random_streams();

    item_ch.valid <= 1'b0;
    guard = 0;
    while (expected_matches.size() != 0 && guard < 5000) begin
      @(posedge clk);
      guard++;
    end
    repeat (20) @(posedge clk);
    if (expected_matches.size() != 0)
      flag_error($sformatf("%0d expected matches never arrived", expected_matches.size()));

    $display("Summary: %0d words sent, %0d matches checked, %0d length writes (0 to 127).",
             word_count, match_count, length_writes);
    $display("Covered: one-byte and 64-byte patterns, restarts, short text, unused kind.");
    if (error_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("Verification failed");
    $finish;
  end

endmodule

// ===== filelist.f =====
rtl/spm_pkg.sv
rtl/spm_if.sv
rtl/spm_cell.sv
rtl/spm_row.sv
rtl/streaming_pattern_matcher.sv
sim/testbench.sv
